// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL; empty when synthesized.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define EDBD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");
`define EDBD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("%m: forbidden condition seen");
`else
`define EDBD_ASSERT(lbl, clk, rst_n, prop)
`define EDBD_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ===== hw/rtl/edbd_pkg.sv =====
// Constants and types shared by the effective bit depth detector.
package edbd_pkg;
	localparam logic [5:0] DEPTH_RESET = 6'd24;
	localparam logic [5:0] DEPTH_MIN   = 6'd1;
	localparam logic [5:0] DEPTH_MAX   = 6'd32;
	localparam int         CONF_BITS   = 17;
	localparam int         QUEUE_DEPTH = 2;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_PREP  = 5'b00010,
		ST_CHECK = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_DONE  = 5'b10000
	} back_state_t;
endpackage

// ===== hw/rtl/effective_bit_depth_detector_top.sv =====
// Throughput: one sample per cycle while full is low; full rises only while two reports
// wait in the queue. A snapshot queued on its last sample passes the back-end states
// IDLE, PREP, CHECK, the 17-step restoring divider when a dither figure is due, and DONE.
// Reset: accumulators and counters cleared, container depth 24, no result pending.
// Top level of the effective bit depth detector: front, snapshot queue, back.
`include "assert_macros.svh"

module effective_bit_depth_detector_top #(
	parameter int COUNT_WIDTH  = 32,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [31:0]                   sample,
	input  logic                          start_req,
	input  logic                          last,
	input  logic                          cfg_wr_en,
	input  logic [5:0]                    cfg_wr_data,
	output logic                          empty,
	input  logic                          pop,
	output logic [5:0]                    effective_depth,
	output logic                          silent,
	output logic                          dither_likely,
	output logic [edbd_pkg::CONF_BITS-1:0] dither_confidence
);
	localparam int QW = SAMPLE_WIDTH + 1 + 2 * COUNT_WIDTH + 6;

	logic                    q_full, q_push, q_empty, q_pop;
	logic [QW-1:0]           q_wdata, q_rdata;
	logic [SAMPLE_WIDTH-1:0] f_comb, b_comb;
	logic                    f_any, b_any;
	logic [COUNT_WIDTH-1:0]  f_trans, f_tog, b_trans, b_tog;
	logic [5:0]              f_depth, b_depth;

	edbd_front #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.sample     (sample),
		.start_req  (start_req),
		.last       (last),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_comb     (f_comb),
		.q_any      (f_any),
		.q_trans    (f_trans),
		.q_tog      (f_tog),
		.q_depth    (f_depth)
	);

	assign q_wdata = {f_comb, f_any, f_trans, f_tog, f_depth};
	assign {b_comb, b_any, b_trans, b_tog, b_depth} = q_rdata;

	edbd_fifo #(
		.WIDTH(QW),
		.DEPTH(edbd_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.full  (q_full),
		.pop   (q_pop),
		.rdata (q_rdata),
		.empty (q_empty)
	);

	edbd_back #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_empty          (q_empty),
		.q_pop            (q_pop),
		.q_comb           (b_comb),
		.q_any            (b_any),
		.q_trans          (b_trans),
		.q_tog            (b_tog),
		.q_depth          (b_depth),
		.pop              (pop),
		.empty            (empty),
		.effective_depth  (effective_depth),
		.silent           (silent),
		.dither_likely    (dither_likely),
		.dither_confidence(dither_confidence)
	);

	`EDBD_ASSERT(a_queue_no_overflow, clk, arst_n, q_push |-> !q_full)
	`EDBD_ASSERT(a_pop_needs_entry, clk, arst_n, q_pop |-> !q_empty)
	`EDBD_ASSERT(a_conf_needs_dither, clk, arst_n, (!empty && !dither_likely) |-> (dither_confidence == '0))
	`EDBD_ASSERT_NEVER(a_silent_no_dither, clk, arst_n, !empty && silent && dither_likely)
	`EDBD_ASSERT(a_depth_in_range, clk, arst_n, !empty |-> (effective_depth != 6'd0 && effective_depth <= edbd_pkg::DEPTH_MAX))
endmodule

// ===== hw/rtl/edbd_front.sv =====
// Front end: accepts samples, updates the accumulators, emits a report snapshot on last.
module edbd_front #(
	parameter int COUNT_WIDTH  = 32,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic [31:0]             sample,
	input  logic                    start_req,
	input  logic                    last,
	input  logic                    cfg_wr_en,
	input  logic [5:0]              cfg_wr_data,
	input  logic                    q_full,
	output logic                    q_push,
	output logic [SAMPLE_WIDTH-1:0] q_comb,
	output logic                    q_any,
	output logic [COUNT_WIDTH-1:0]  q_trans,
	output logic [COUNT_WIDTH-1:0]  q_tog,
	output logic [5:0]              q_depth
);
	logic [5:0]              depth_q;
	logic [SAMPLE_WIDTH-1:0] comb_q, comb_b, comb_n, s;
	logic                    any_q, any_b, any_n;
	logic                    hp_q, hp_b;
	logic                    prev_q, prev_b;
	logic [COUNT_WIDTH-1:0]  tr_q, tr_b, tr_n, tg_q, tg_b, tg_n;
	logic                    accept, bump;

	assign accept = push & ~q_full;
	assign full   = q_full;
	assign s      = sample[SAMPLE_WIDTH-1:0];

	always_comb begin
		comb_b = start_req ? '0 : comb_q;
		any_b  = start_req ? 1'b0 : any_q;
		hp_b   = start_req ? 1'b0 : hp_q;
		prev_b = start_req ? 1'b0 : prev_q;
		tr_b   = start_req ? '0 : tr_q;
		tg_b   = start_req ? '0 : tg_q;
		comb_n = comb_b | s;
		any_n  = any_b | (|s);
		bump   = hp_b & ~(&tr_b);
		tr_n   = bump ? tr_b + COUNT_WIDTH'(1) : tr_b;
		tg_n   = (bump && (prev_b != s[0])) ? tg_b + COUNT_WIDTH'(1) : tg_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= edbd_pkg::DEPTH_RESET;
			comb_q  <= '0;
			any_q   <= 1'b0;
			hp_q    <= 1'b0;
			prev_q  <= 1'b0;
			tr_q    <= '0;
			tg_q    <= '0;
		end else begin
			if (cfg_wr_en) begin
				depth_q <= cfg_wr_data;
			end
			if (accept) begin
				comb_q <= comb_n;
				any_q  <= any_n;
				hp_q   <= 1'b1;
				prev_q <= s[0];
				tr_q   <= tr_n;
				tg_q   <= tg_n;
			end
		end
	end

	always_comb begin
		if (depth_q == 6'd0) begin
			q_depth = edbd_pkg::DEPTH_MIN;
		end else if (depth_q > edbd_pkg::DEPTH_MAX) begin
			q_depth = edbd_pkg::DEPTH_MAX;
		end else begin
			q_depth = depth_q;
		end
	end

	assign q_push  = accept & last;
	assign q_comb  = comb_n;
	assign q_any   = any_n;
	assign q_trans = tr_n;
	assign q_tog   = tg_n;
endmodule

// ===== hw/rtl/edbd_fifo.sv =====
// Short register queue carrying report snapshots from front to back.
module edbd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end
endmodule

// ===== hw/rtl/edbd_back.sv =====
// Back end: depth evaluation, dither confidence division and the result register.
module edbd_back #(
	parameter int COUNT_WIDTH  = 32,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	output logic                          q_pop,
	input  logic [SAMPLE_WIDTH-1:0]       q_comb,
	input  logic                          q_any,
	input  logic [COUNT_WIDTH-1:0]        q_trans,
	input  logic [COUNT_WIDTH-1:0]        q_tog,
	input  logic [5:0]                    q_depth,
	input  logic                          pop,
	output logic                          empty,
	output logic [5:0]                    effective_depth,
	output logic                          silent,
	output logic                          dither_likely,
	output logic [edbd_pkg::CONF_BITS-1:0] dither_confidence
);
	localparam int KW   = $clog2(SAMPLE_WIDTH);
	localparam int DW   = COUNT_WIDTH + 2;
	localparam int RW   = COUNT_WIDTH + 3;
	localparam int TW   = COUNT_WIDTH + 4;
	localparam int CNTW = $clog2(edbd_pkg::CONF_BITS);

	edbd_pkg::back_state_t state_q;

	logic [SAMPLE_WIDTH-1:0]        lowest;
	logic [KW-1:0]                  k;
	logic [5:0]                     k6, eff;
	logic [COUNT_WIDTH:0]           t2, n1, diff;
	logic [DW-1:0]                  den;
	logic [TW-1:0]                  ten_a, den_t, num;
	logic                           lt;
	logic                           ge;
	logic [RW-1:0]                  rem_sub;

	logic [COUNT_WIDTH-1:0]         a_q;
	logic [DW-1:0]                  den_q;
	logic [5:0]                     eff_q;
	logic                           silent_q, chk_q, likely_q;
	logic [RW-1:0]                  rem_q;
	logic [edbd_pkg::CONF_BITS-1:0] quo_q;
	logic [CNTW-1:0]                cnt_q;
	logic                           res_valid_q, load;

	logic [5:0]                     res_eff_q;
	logic                           res_silent_q, res_likely_q;
	logic [edbd_pkg::CONF_BITS-1:0] res_conf_q;

	always_comb begin
		lowest = q_comb & (~q_comb + SAMPLE_WIDTH'(1));
		k = '0;
		for (int b = 0; b < KW; b++) begin
			for (int i = 0; i < SAMPLE_WIDTH; i++) begin
				if (((i >> b) & 1) == 1) begin
					k[b] = k[b] | lowest[i];
				end
			end
		end
		k6  = 6'(k);
		eff = (!q_any || k6 >= q_depth) ? q_depth : q_depth - k6;
		t2   = {q_tog, 1'b0};
		n1   = {1'b0, q_trans};
		diff = (t2 >= n1) ? t2 - n1 : n1 - t2;
		den  = DW'({q_trans, 1'b0}) + DW'(q_trans);
	end

	always_comb begin
		ten_a   = TW'({a_q, 3'b000}) + TW'({a_q, 1'b0});
		den_t   = TW'(den_q);
		lt      = ten_a < den_t;
		num     = den_t - ten_a;
		ge      = rem_q >= RW'(den_q);
		rem_sub = ge ? rem_q - RW'(den_q) : rem_q;
	end

	assign q_pop = (state_q == edbd_pkg::ST_PREP);
	assign load  = (state_q == edbd_pkg::ST_DONE) && (!res_valid_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= edbd_pkg::ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				edbd_pkg::ST_IDLE: begin
					if (!q_empty) begin
						state_q <= edbd_pkg::ST_PREP;
					end
				end
				edbd_pkg::ST_PREP: begin
					state_q <= edbd_pkg::ST_CHECK;
				end
				edbd_pkg::ST_CHECK: begin
					state_q <= (chk_q && lt) ? edbd_pkg::ST_DIV : edbd_pkg::ST_DONE;
				end
				edbd_pkg::ST_DIV: begin
					if (cnt_q == CNTW'(edbd_pkg::CONF_BITS - 1)) begin
						state_q <= edbd_pkg::ST_DONE;
					end
				end
				edbd_pkg::ST_DONE: begin
					if (load) begin
						state_q <= edbd_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= edbd_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == edbd_pkg::ST_PREP) begin
			a_q      <= diff[COUNT_WIDTH-1:0];
			den_q    <= den;
			eff_q    <= eff;
			silent_q <= ~q_any;
			chk_q    <= q_comb[0] && (q_trans != '0);
		end
		if (state_q == edbd_pkg::ST_CHECK) begin
			likely_q <= chk_q && lt;
			rem_q    <= RW'(num);
			quo_q    <= '0;
			cnt_q    <= '0;
		end
		if (state_q == edbd_pkg::ST_DIV) begin
			rem_q <= {rem_sub[RW-2:0], 1'b0};
			quo_q <= {quo_q[edbd_pkg::CONF_BITS-2:0], ge};
			cnt_q <= cnt_q + CNTW'(1);
		end
		if (load) begin
			res_eff_q    <= eff_q;
			res_silent_q <= silent_q;
			res_likely_q <= likely_q;
			res_conf_q   <= likely_q ? quo_q : '0;
		end
	end

	assign empty             = ~res_valid_q;
	assign effective_depth   = res_eff_q;
	assign silent            = res_silent_q;
	assign dither_likely     = res_likely_q;
	assign dither_confidence = res_conf_q;
endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the effective bit depth detector: queued stimulus, scoreboard.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RESET_CYCLES   = 12;
	localparam int SETTLE_CYCLES  = 30;
	localparam int QUIET_TAIL     = 150;
	localparam int SAMPLE_TARGET  = 1170;
	localparam int PHASE_SAMPLES  = 100;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SHOWN_ERRORS   = 10;

	typedef enum logic {
		ENTRY_SAMPLE,
		ENTRY_DEPTH
	} entry_kind_t;

	typedef struct {
		entry_kind_t kind;
		logic [31:0] smp;
		logic        st;
		logic        lst;
		logic [5:0]  depth;
	} stim_entry_t;

	typedef struct packed {
		logic [5:0]                     eff_depth;
		logic                           silent;
		logic                           likely;
		logic [edbd_pkg::CONF_BITS-1:0] conf;
	} depth_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic [31:0] sample = '0;
	logic start_req = 1'b0;
	logic last = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [5:0] cfg_wr_data = '0;
	logic pop = 1'b0;
	logic full;
	logic empty;
	logic [5:0] effective_depth;
	logic silent;
	logic dither_likely;
	logic [edbd_pkg::CONF_BITS-1:0] dither_confidence;

	stim_entry_t   pending[$];
	depth_report_t report_q[$];
	int            errors = 0;
	int            queued_samples = 0;
	int            quiet_cycles = 0;

	logic [5:0]  depth_reg = edbd_pkg::DEPTH_RESET;
	logic [31:0] bit_mask;
	logic        seen_nonzero;
	logic        have_prev;
	logic        prev_lsb;
	logic [31:0] trans_cnt;
	logic [31:0] toggle_cnt;

	effective_bit_depth_detector_top dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.push              (push),
		.full              (full),
		.sample            (sample),
		.start_req         (start_req),
		.last              (last),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_wr_data       (cfg_wr_data),
		.empty             (empty),
		.pop               (pop),
		.effective_depth   (effective_depth),
		.silent            (silent),
		.dither_likely     (dither_likely),
		.dither_confidence (dither_confidence)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void note_error(string msg);
		errors++;
		if (errors <= SHOWN_ERRORS) begin
			$display("%s", msg);
		end
	endfunction

	function automatic void clear_accumulators();
		bit_mask = '0;
		seen_nonzero = 1'b0;
		have_prev = 1'b0;
		prev_lsb = 1'b0;
		trans_cnt = '0;
		toggle_cnt = '0;
	endfunction

	function automatic void detect_step(logic [31:0] smp, logic st, logic lst);
		depth_report_t rpt;
		logic [5:0] dep;
		int tz;
		logic [63:0] n, t2, a, den, num;
		if (st) begin
			clear_accumulators();
		end
		if (smp != '0) begin
			bit_mask |= smp;
			seen_nonzero = 1'b1;
		end
		if (have_prev && trans_cnt != '1) begin
			trans_cnt++;
			if (prev_lsb != smp[0]) begin
				toggle_cnt++;
			end
		end
		prev_lsb = smp[0];
		have_prev = 1'b1;
		if (!lst) begin
			return;
		end
		if (depth_reg < edbd_pkg::DEPTH_MIN) begin
			dep = edbd_pkg::DEPTH_MIN;
		end else if (depth_reg > edbd_pkg::DEPTH_MAX) begin
			dep = edbd_pkg::DEPTH_MAX;
		end else begin
			dep = depth_reg;
		end
		rpt = '{eff_depth: dep, silent: !seen_nonzero, likely: 1'b0, conf: '0};
		if (seen_nonzero) begin
			tz = 0;
			while (!bit_mask[tz]) begin
				tz++;
			end
			rpt.eff_depth = (tz >= int'(dep)) ? dep : 6'(int'(dep) - tz);
			if (tz == 0 && trans_cnt != '0) begin
				n = 64'(trans_cnt);
				t2 = 64'(toggle_cnt) * 2;
				a = (t2 >= n) ? t2 - n : n - t2;
				den = 3 * n;
				if (10 * a < den) begin
					num = den - 10 * a;
					num = (num << 16) / den;
					rpt.likely = 1'b1;
					rpt.conf = num[edbd_pkg::CONF_BITS-1:0];
				end
			end
		end
		report_q.push_back(rpt);
	endfunction

	task automatic add_sample(logic [31:0] smp, logic st, logic lst);
		pending.push_back('{kind: ENTRY_SAMPLE, smp: smp, st: st, lst: lst, depth: '0});
		queued_samples++;
	endtask

	task automatic add_depth(logic [5:0] d);
		pending.push_back('{kind: ENTRY_DEPTH, smp: '0, st: 1'b0, lst: 1'b0, depth: d});
	endtask

	task automatic add_analysis(int len, bit with_start);
		int mode, shift, flip_pct;
		logic [31:0] s;
		logic l;
		mode = $urandom_range(7);
		shift = $urandom_range(31);
		flip_pct = $urandom_range(100);
		l = $urandom_range(1);
		for (int i = 0; i < len; i++) begin
			case (mode)
				0, 1: s = $urandom();
				2: s = ($urandom() | 32'h1) << shift;
				3: s = '0;
				7: s = $urandom_range(16) - 8;
				default: begin
					if ($urandom_range(99) < flip_pct) begin
						l = ~l;
					end
					s = $urandom();
					s[0] = l;
				end
			endcase
			add_sample(s, (with_start && i == 0) || $urandom_range(39) == 0, i == len - 1);
		end
	endtask

	task automatic add_noise(int len);
		for (int i = 0; i < len; i++) begin
			add_sample($urandom(), $urandom_range(7) == 0, $urandom_range(7) == 0);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : driver
		logic next_push;
		logic next_cfg;
		int   feed_gap;
		int   settle;
		if (!arst_n) begin
			push <= 1'b0;
			sample <= '0;
			start_req <= 1'b0;
			last <= 1'b0;
			cfg_wr_en <= 1'b0;
			cfg_wr_data <= '0;
			feed_gap = 0;
			settle = 0;
			depth_reg = edbd_pkg::DEPTH_RESET;
			clear_accumulators();
		end else begin
			next_push = 1'b0;
			next_cfg = 1'b0;
			if (push && !full) begin
				detect_step(sample, start_req, last);
				void'(pending.pop_front());
			end
			if (cfg_wr_en) begin
				depth_reg = cfg_wr_data;
				void'(pending.pop_front());
			end
			if (push || report_q.size() != 0) begin
				settle = 0;
			end else if (settle < SETTLE_CYCLES) begin
				settle++;
			end
			if (pending.size() != 0) begin
				if (pending[0].kind == ENTRY_DEPTH) begin
					next_cfg = !cfg_wr_en && settle >= SETTLE_CYCLES && report_q.size() == 0;
				end else if (push && full) begin
					next_push = 1'b1;
				end else if (feed_gap != 0) begin
					feed_gap--;
				end else if (pending.size() > QUIET_TAIL && $urandom_range(5) == 0) begin
					feed_gap = $urandom_range(2);
				end else begin
					next_push = 1'b1;
				end
			end
			push <= next_push;
			cfg_wr_en <= next_cfg;
			if (next_push) begin
				sample <= pending[0].smp;
				start_req <= pending[0].st;
				last <= pending[0].lst;
			end
			if (next_cfg) begin
				cfg_wr_data <= pending[0].depth;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		logic next_pop;
		int   drain_gap;
		depth_report_t want;
		if (!arst_n) begin
			pop <= 1'b0;
			drain_gap = 0;
		end else begin
			if (pop && !empty) begin
				if (report_q.size() == 0) begin
					note_error($sformatf("unexpected report: depth %0d silent %0b likely %0b conf %0d",
						effective_depth, silent, dither_likely, dither_confidence));
				end else begin
					want = report_q.pop_front();
					if (effective_depth !== want.eff_depth || silent !== want.silent ||
						dither_likely !== want.likely || dither_confidence !== want.conf) begin
						note_error($sformatf({"report mismatch: expected depth %0d silent %0b ",
							"likely %0b conf %0d, got depth %0d silent %0b likely %0b conf %0d"},
							want.eff_depth, want.silent, want.likely, want.conf,
							effective_depth, silent, dither_likely, dither_confidence));
					end
				end
			end
			next_pop = 1'b1;
			if (drain_gap != 0) begin
				drain_gap--;
				next_pop = 1'b0;
			end else if (pending.size() > QUIET_TAIL && $urandom_range(4) == 0) begin
				drain_gap = $urandom_range(2);
				next_pop = 1'b0;
			end
			pop <= next_pop;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || cfg_wr_en) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : watchdog
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stimulus
		logic [5:0] depth_plan[6];
		int phase;
		int next_phase;
		depth_plan = '{edbd_pkg::DEPTH_MAX, 6'd0, edbd_pkg::DEPTH_MIN, 6'd63,
			edbd_pkg::DEPTH_RESET, 6'd33};
		phase = 0;

		// no start after reset, reset depth, extreme sample values
		add_sample(32'h7FFF_FFFF, 1'b0, 1'b0);
		add_sample(32'h8000_0000, 1'b0, 1'b0);
		add_sample(32'hFFFF_FFFF, 1'b0, 1'b1);
		add_sample(32'h0, 1'b0, 1'b1);
		add_sample(32'h0, 1'b1, 1'b0);
		add_sample(32'h0, 1'b0, 1'b1);
		add_sample(32'h1, 1'b1, 1'b1);
		add_depth(6'd4);
		add_sample(32'h0000_0100, 1'b1, 1'b0);
		add_sample(32'hFFFF_FF00, 1'b0, 1'b1);
		add_depth(6'd16);
		add_sample(32'h10, 1'b1, 1'b0);
		add_sample(32'h30, 1'b0, 1'b0);
		add_sample(32'hFFF0, 1'b0, 1'b1);
		add_depth(6'd0);
		add_sample(32'h3, 1'b1, 1'b0);
		add_sample(32'h2, 1'b0, 1'b1);
		add_depth(6'd63);
		add_sample(32'h1, 1'b1, 1'b0);
		add_sample(32'h3, 1'b0, 1'b0);
		add_sample(32'h2, 1'b0, 1'b0);
		add_sample(32'h4, 1'b0, 1'b0);
		add_sample(32'h5, 1'b0, 1'b1);

		next_phase = queued_samples;
		while (queued_samples < SAMPLE_TARGET) begin
			if (queued_samples >= next_phase) begin
				add_depth(phase < 6 ? depth_plan[phase] : 6'($urandom_range(63)));
				phase++;
				next_phase += PHASE_SAMPLES;
			end
			if ($urandom_range(9) == 0) begin
				add_noise($urandom_range(1, 12));
			end else begin
				add_analysis($urandom_range(3) == 0 ? $urandom_range(1, 60) : $urandom_range(1, 16),
					$urandom_range(7) != 0);
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		while (pending.size() != 0 || report_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
